// ----- rtl/xed_pkg.sv -----
package xed_pkg;

  // default maximum length of a reference name
  localparam int NAME_CAPACITY_DEF = 16;

  localparam int COUNT_W = 16;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ENTITY = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_INVALID    = 2'd3
  } status_t;

  // register indexes (word address bit 2)
  localparam logic REG_WRITE_MODE = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  // configuration as seen by the decoder
  typedef struct packed {
    logic               write_mode;
    logic [COUNT_W-1:0] max_length;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [7:0]         out_byte;
    logic               is_final;
    logic [COUNT_W-1:0] byte_count;
    status_t            status;
  } result_t;

  // named entities: text packed low byte first, length, decoded value
  localparam int ENT_NUM = 5;
  localparam logic [31:0] ENT_TEXT [ENT_NUM] = '{
    32'h0000_746C,   // lt
    32'h0000_7467,   // gt
    32'h0070_6D61,   // amp
    32'h736F_7061,   // apos
    32'h746F_7571    // quot
  };
  localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4};
  localparam logic [7:0] ENT_VALUE [ENT_NUM] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22};

endpackage

// ----- rtl/xed_cfg_regs.sv -----
module xed_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output xed_pkg::cfg_t cfg
);
  import xed_pkg::*;

  logic               write_mode_r;
  logic [COUNT_W-1:0] max_length_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes, word index in paddr[2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_mode_r <= 1'b1;
      max_length_r <= {COUNT_W{1'b1}};
    end else if (wr_en) begin
      case (paddr[2])
        REG_WRITE_MODE: write_mode_r <= pwdata[0];
        REG_MAX_LENGTH: max_length_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      REG_WRITE_MODE: prdata = {31'd0, write_mode_r};
      REG_MAX_LENGTH: prdata = {{(32-COUNT_W){1'b0}}, max_length_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.write_mode = write_mode_r;
  assign cfg.max_length = max_length_r;

endmodule

// ----- rtl/xed_decode_core.sv -----
module xed_decode_core #(
  parameter int NAME_CAPACITY = xed_pkg::NAME_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       byte_in,
  input  xed_pkg::cfg_t    cfg,
  output logic             res_valid,
  output xed_pkg::result_t res
);
  import xed_pkg::*;

  localparam int LEN_W = $clog2(NAME_CAPACITY + 1);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;

  // string state
  logic               in_ref_r,  in_ref_nxt;
  logic [LEN_W-1:0]   len_r,     len_nxt;
  logic [COUNT_W-1:0] count_r,   count_nxt;
  status_t            err_r,     err_nxt;
  // reference trackers, updated byte by byte in place of a name buffer
  logic               is_num_r,  is_num_nxt;
  logic               is_hex_r,  is_hex_nxt;
  logic               num_ok_r,  num_ok_nxt;
  logic [7:0]         acc_r,     acc_nxt;
  logic [ENT_NUM-1:0] match_r,   match_nxt;

  logic               invalid;
  logic               digit_pos;
  logic               dig_ok;
  logic [3:0]         dig_val;
  logic [7:0]         acc_step;
  logic [ENT_NUM-1:0] match_step;
  logic               tr_bad;
  logic [7:0]         tr_value;
  logic [COUNT_W:0]   next_cnt;
  logic [COUNT_W-1:0] sat_cnt;
  logic               over;

  assign invalid = cfg.write_mode ? (cfg.max_length == '0) : (cfg.max_length != '0);

  // digit decode of the incoming name byte
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
      dig_ok  = 1'b1;
      dig_val = 4'(byte_in - 8'h30);
    end else if (is_hex_r && byte_in >= 8'h61 && byte_in <= 8'h66) begin
      dig_ok  = 1'b1;
      dig_val = 4'(byte_in - 8'h61 + 8'd10);
    end else if (is_hex_r && byte_in >= 8'h41 && byte_in <= 8'h46) begin
      dig_ok  = 1'b1;
      dig_val = 4'(byte_in - 8'h41 + 8'd10);
    end
  end

  // a digit sits after '#', or after "#x" once hex is seen
  assign digit_pos = is_num_r &&
                     ((len_r >= LEN_W'(2)) || (len_r == LEN_W'(1) && byte_in != CH_X));

  // accumulate modulo 256: times 16 is a shift, times 10 is 8x + 2x
  assign acc_step = is_hex_r ? ({acc_r[3:0], 4'd0} + {4'd0, dig_val})
                             : ({acc_r[4:0], 3'd0} + {acc_r[6:0], 1'b0} + {4'd0, dig_val});

  // prefix match against each named entity
  always_comb begin
    for (int i = 0; i < ENT_NUM; i++) begin
      match_step[i] = match_r[i] &&
                      !(len_r < LEN_W'(ENT_LEN[i]) &&
                        byte_in != ENT_TEXT[i][{len_r[1:0], 3'b000} +: 8]);
    end
  end

  // name translation at ';'
  always_comb begin
    tr_bad   = 1'b1;
    tr_value = 8'd0;
    if (len_r == '0) begin
      tr_bad = 1'b1;
    end else if (is_num_r) begin
      tr_value = acc_r;
      if (len_r <= (is_hex_r ? LEN_W'(2) : LEN_W'(1))) tr_bad = 1'b1;
      else tr_bad = !num_ok_r;
    end else begin
      // scan downward so the first listed entity wins
      for (int i = ENT_NUM - 1; i >= 0; i--) begin
        if (match_r[i] && len_r >= LEN_W'(ENT_LEN[i])) begin
          tr_bad   = 1'b0;
          tr_value = ENT_VALUE[i];
        end
      end
    end
  end

  // count with saturation; overflow uses the unsaturated value
  assign next_cnt = {1'b0, count_r} + {{COUNT_W{1'b0}}, 1'b1};
  assign sat_cnt  = next_cnt[COUNT_W] ? {COUNT_W{1'b1}} : next_cnt[COUNT_W-1:0];
  assign over     = cfg.write_mode && (next_cnt > {1'b0, cfg.max_length});

  // per-byte step
  always_comb begin
    in_ref_nxt = in_ref_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    is_num_nxt = is_num_r;
    is_hex_nxt = is_hex_r;
    num_ok_nxt = num_ok_r;
    acc_nxt    = acc_r;
    match_nxt  = match_r;
    res_valid  = 1'b0;
    res.out_byte   = 8'd0;
    res.is_final   = 1'b0;
    res.byte_count = count_r;
    res.status     = ST_OK;
    if (fire) begin
      if (byte_in == CH_NUL) begin
        // terminator: summary, then back to a fresh string
        res_valid    = 1'b1;
        res.is_final = 1'b1;
        if (err_r != ST_OK)  res.status = err_r;
        else if (invalid)    res.status = ST_INVALID;
        else if (in_ref_r)   res.status = ST_BAD_ENTITY;
        in_ref_nxt = 1'b0;
        len_nxt    = '0;
        count_nxt  = '0;
        err_nxt    = ST_OK;
      end else if (err_r != ST_OK) begin
        // held error: ignore until terminator
      end else if (invalid) begin
        err_nxt = ST_INVALID;
      end else if (in_ref_r && byte_in != CH_SEMI) begin
        // name byte
        if (len_r >= LEN_W'(NAME_CAPACITY)) begin
          err_nxt = ST_BAD_ENTITY;
        end else begin
          len_nxt   = len_r + LEN_W'(1);
          match_nxt = match_step;
          if (len_r == '0) is_num_nxt = (byte_in == CH_HASH);
          if (is_num_r && len_r == LEN_W'(1) && byte_in == CH_X) is_hex_nxt = 1'b1;
          if (digit_pos) begin
            if (dig_ok) acc_nxt = acc_step;
            else        num_ok_nxt = 1'b0;
          end
        end
      end else if (!in_ref_r && byte_in == CH_AMP) begin
        // reference opens
        in_ref_nxt = 1'b1;
        len_nxt    = '0;
        is_num_nxt = 1'b0;
        is_hex_nxt = 1'b0;
        num_ok_nxt = 1'b1;
        acc_nxt    = 8'd0;
        match_nxt  = {ENT_NUM{1'b1}};
      end else begin
        // plain byte or reference close: one decoded byte
        count_nxt = sat_cnt;
        if (in_ref_r) begin
          in_ref_nxt = 1'b0;
          len_nxt    = '0;
        end
        if (in_ref_r && tr_bad) begin
          err_nxt = ST_BAD_ENTITY;
        end else if (over) begin
          err_nxt = ST_OVERFLOW;
        end else if (cfg.write_mode) begin
          res_valid      = 1'b1;
          res.out_byte   = in_ref_r ? tr_value : byte_in;
          res.byte_count = sat_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ref_r <= 1'b0;
      len_r    <= '0;
      count_r  <= '0;
      err_r    <= ST_OK;
    end else begin
      in_ref_r <= in_ref_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
    end
  end

  // trackers are rearmed at each '&' that opens a reference
  always_ff @(posedge clk) begin
    is_num_r <= is_num_nxt;
    is_hex_r <= is_hex_nxt;
    num_ok_r <= num_ok_nxt;
    acc_r    <= acc_nxt;
    match_r  <= match_nxt;
  end

endmodule

// ----- rtl/xml_entity_reference_decoder_top.sv -----
// Each byte is held in the input register, then decoded into the
// result register.
// Throughput: one byte per cycle; the input stalls only while a result
// is held under out_stall and the input register is occupied.
// Reset (rst_n low, synchronous): string state cleared, write_mode = 1,
// max_length = 65535.
module xml_entity_reference_decoder_top #(
  parameter int NAME_CAPACITY = xed_pkg::NAME_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_is_final,
  output logic [xed_pkg::COUNT_W-1:0] out_byte_count,
  output logic [1:0]                  out_status,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import xed_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic       adv;
  logic       fire;

  xed_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xed_decode_core #(
    .NAME_CAPACITY (NAME_CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_in   (s1_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // pipeline advance: result register free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = adv ? (fire && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_byte_r <= in_byte;
    if (fire && res_valid)     out_r     <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_r.out_byte;
  assign out_is_final   = out_r.is_final;
  assign out_byte_count = out_r.byte_count;
  assign out_status     = out_r.status;

endmodule

// ----- rtl/xed_checker.sv -----
module xed_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [7:0]                  out_byte,
  input logic                        out_is_final,
  input logic [xed_pkg::COUNT_W-1:0] out_byte_count,
  input logic [1:0]                  out_status
);
  import xed_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_is_final) && $stable(out_byte_count) && $stable(out_status))
    else $error("result changed while stalled");

  // input backpressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // byte results always carry ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_status == ST_OK)
    else $error("byte result with error status");

  // byte results count themselves
  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_byte_count != '0)
    else $error("byte result with zero count");

  // summary carries a zero byte
  a_final_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_final |-> out_byte == 8'h00)
    else $error("summary with nonzero byte");

endmodule

bind xml_entity_reference_decoder_top xed_checker u_chk (.*);
